>>> rtl/polar_to_cartesian_range_gate_defines.svh
// assertion macros for the polar to cartesian range gate
`ifndef POLAR_TO_CARTESIAN_RANGE_GATE_DEFINES_SVH
`define POLAR_TO_CARTESIAN_RANGE_GATE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define P2C_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define P2C_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define P2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/p2c_pkg.sv
package p2c_pkg;

  // field and datapath widths
  localparam int RANGE_W = 16;
  localparam int INDEX_W = 12;
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 17;
  localparam int XY_W    = 35;
  localparam int Z_W     = 34;
  localparam int ARC_LEN = 24;

  // samples at or beyond this index are dropped
  localparam int MAX_SAMPLES = 4096;

  // cordic gain compensation, 0.60725 in Q0.32
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  // rounding and output clamp in the Q16 datapath
  localparam logic signed [XY_W-1:0] ROUND_HALF = 35'sd32768;
  localparam logic signed [XY_W-1:0] SAT_HI     = 35'sd65535;
  localparam logic signed [XY_W-1:0] SAT_LO     = -35'sd65535;

  // quarter and half turn in binary angle units
  localparam logic signed [ANGLE_W:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [ANGLE_W:0] HALF_TURN    = 17'sd32768;

  // register map, word index
  typedef enum logic [1:0] {
    REG_START_ANGLE   = 2'd0,
    REG_ANGLE_STEP    = 2'd1,
    REG_RANGE_FLOOR   = 2'd2,
    REG_RANGE_CEILING = 2'd3
  } reg_addr_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] arc_angle(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:    a = 30'h20000000;
      5'd1:    a = 30'h12E4051D;
      5'd2:    a = 30'h09FB385B;
      5'd3:    a = 30'h051111D4;
      5'd4:    a = 30'h028B0D43;
      5'd5:    a = 30'h0145D7E1;
      5'd6:    a = 30'h00A2F61E;
      5'd7:    a = 30'h00517C55;
      5'd8:    a = 30'h0028BE53;
      5'd9:    a = 30'h00145F2E;
      5'd10:   a = 30'h000A2F98;
      5'd11:   a = 30'h000517CC;
      5'd12:   a = 30'h00028BE6;
      5'd13:   a = 30'h000145F3;
      5'd14:   a = 30'h0000A2F9;
      5'd15:   a = 30'h0000517C;
      5'd16:   a = 30'h000028BE;
      5'd17:   a = 30'h0000145F;
      5'd18:   a = 30'h00000A2F;
      5'd19:   a = 30'h00000517;
      5'd20:   a = 30'h0000028B;
      5'd21:   a = 30'h00000145;
      5'd22:   a = 30'h000000A2;
      5'd23:   a = 30'h00000051;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

  // Q16 to millimeters, round half up, clamp to the output range
  function automatic logic signed [OUT_W-1:0] to_mm(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + ROUND_HALF) >>> 16;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return OUT_W'(r);
  endfunction

endpackage

>>> rtl/polar_to_cartesian_range_gate.sv
// pipeline: stage 1, the start vector register, one register per rotation stage, output register
// throughput: one beat per cycle; the whole pipeline advances whenever the
//   output register is empty or being taken, so a stall holds every stage
// reset (rst, synchronous): clears all valid bits and loads the register
//   defaults (start 0, step 0, floor 0, ceiling 65535)
module polar_to_cartesian_range_gate #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [p2c_pkg::RANGE_W-1:0]         range_mm,
  input  logic [p2c_pkg::INDEX_W-1:0]         sample_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [p2c_pkg::OUT_W-1:0]    x_mm,
  output logic signed [p2c_pkg::OUT_W-1:0]    y_mm,
  output logic [p2c_pkg::INDEX_W-1:0]         point_index
);

  `include "polar_to_cartesian_range_gate_defines.svh"

  localparam int STAGES = (CORDIC_STAGES > p2c_pkg::ARC_LEN) ? p2c_pkg::ARC_LEN
                                                             : CORDIC_STAGES;
  localparam int XY_W = p2c_pkg::XY_W;
  localparam int Z_W  = p2c_pkg::Z_W;

  // configuration registers
  logic [p2c_pkg::ANGLE_W-1:0] start_angle;
  logic [p2c_pkg::ANGLE_W-1:0] angle_step;
  logic [p2c_pkg::RANGE_W-1:0] range_floor;
  logic [p2c_pkg::RANGE_W-1:0] range_ceiling;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle   <= '0;
      angle_step    <= '0;
      range_floor   <= '0;
      range_ceiling <= '1;
    end else if (cfg_write) begin
      case (p2c_pkg::reg_addr_t'(paddr[3:2]))
        p2c_pkg::REG_START_ANGLE:   start_angle   <= pwdata[15:0];
        p2c_pkg::REG_ANGLE_STEP:    angle_step    <= pwdata[15:0];
        p2c_pkg::REG_RANGE_FLOOR:   range_floor   <= pwdata[15:0];
        p2c_pkg::REG_RANGE_CEILING: range_ceiling <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (p2c_pkg::reg_addr_t'(paddr[3:2]))
      p2c_pkg::REG_START_ANGLE:   prdata = {16'b0, start_angle};
      p2c_pkg::REG_ANGLE_STEP:    prdata = {16'b0, angle_step};
      p2c_pkg::REG_RANGE_FLOOR:   prdata = {16'b0, range_floor};
      p2c_pkg::REG_RANGE_CEILING: prdata = {16'b0, range_ceiling};
      default:                    prdata = '0;
    endcase
  end

  // global advance: every stage moves when the output slot frees up
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // stage 1: range window, index limit, angle product, gain product
  logic        in_keep;
  logic [27:0] turn_prod;
  logic [47:0] gain_prod;

  assign in_keep = (range_mm > range_floor) && (range_mm < range_ceiling) &&
                   ({5'b0, sample_index} < 17'(p2c_pkg::MAX_SAMPLES));
  assign turn_prod = {16'b0, sample_index} * {12'b0, angle_step};
  assign gain_prod = {32'b0, range_mm} * {16'b0, p2c_pkg::GAIN_Q32};

  logic                        s1_vld;
  logic [p2c_pkg::ANGLE_W-1:0] s1_turn;
  logic [31:0]                 s1_gain;
  logic [p2c_pkg::INDEX_W-1:0] s1_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid && in_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_turn  <= turn_prod[15:0];
      s1_gain  <= gain_prod[47:16];
      s1_index <= sample_index;
    end
  end

  // stage 2: beam angle, fold into the right half plane, start vector
  logic [p2c_pkg::ANGLE_W-1:0]      beam_angle;
  logic signed [p2c_pkg::ANGLE_W:0] beam_ext;
  logic signed [p2c_pkg::ANGLE_W:0] resid;
  logic                             flip;
  logic signed [XY_W-1:0]           x_start;

  assign beam_angle = start_angle + s1_turn;
  assign beam_ext   = {beam_angle[15], beam_angle};

  always_comb begin
    if (beam_ext > p2c_pkg::QUARTER_TURN) begin
      resid = beam_ext - p2c_pkg::HALF_TURN;
      flip  = 1'b1;
    end else if (beam_ext < -p2c_pkg::QUARTER_TURN) begin
      resid = beam_ext + p2c_pkg::HALF_TURN;
      flip  = 1'b1;
    end else begin
      resid = beam_ext;
      flip  = 1'b0;
    end
  end

  assign x_start = flip ? -signed'({3'b0, s1_gain}) : signed'({3'b0, s1_gain});

  // rotation pipeline, entry 0 holds the start vector
  logic [STAGES:0]             vld_pipe;
  logic signed [XY_W-1:0]      x_pipe   [STAGES+1];
  logic signed [XY_W-1:0]      y_pipe   [STAGES+1];
  logic signed [Z_W-1:0]       z_pipe   [STAGES+1];
  logic [p2c_pkg::INDEX_W-1:0] idx_pipe [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else if (advance) begin
      vld_pipe[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_pipe[0]   <= x_start;
      y_pipe[0]   <= '0;
      z_pipe[0]   <= {resid[16], resid, 16'b0};
      idx_pipe[0] <= s1_index;
    end
  end

  // one cordic micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;

    assign dx = y_pipe[i] >>> i;
    assign dy = x_pipe[i] >>> i;
    assign da = signed'(Z_W'(p2c_pkg::arc_angle(5'(i))));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[i+1] <= 1'b0;
      end else if (advance) begin
        vld_pipe[i+1] <= vld_pipe[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        if (!z_pipe[i][Z_W-1]) begin
          x_pipe[i+1] <= x_pipe[i] - dx;
          y_pipe[i+1] <= y_pipe[i] + dy;
          z_pipe[i+1] <= z_pipe[i] - da;
        end else begin
          x_pipe[i+1] <= x_pipe[i] + dx;
          y_pipe[i+1] <= y_pipe[i] - dy;
          z_pipe[i+1] <= z_pipe[i] + da;
        end
        idx_pipe[i+1] <= idx_pipe[i];
      end
    end
  end

  // output register: round to millimeters and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld_pipe[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vld_pipe[STAGES]) begin
      x_mm        <= p2c_pkg::to_mm(x_pipe[STAGES]);
      y_mm        <= p2c_pkg::to_mm(y_pipe[STAGES]);
      point_index <= idx_pipe[STAGES];
    end
  end

  // checks
  `P2C_ASSERT_NEXT(a_reject_drops, clk, rst,
    in_valid && in_ready && !in_keep, !s1_vld, "rejected sample entered the pipeline")
  `P2C_ASSERT_NEXT(a_stall_holds, clk, rst,
    !advance, $stable(vld_pipe) && $stable(s1_vld), "pipeline moved during a stall")
  `P2C_ASSERT_NOW(a_out_clamped, clk, rst,
    out_valid, (x_mm != 17'h10000) && (y_mm != 17'h10000), "output beyond clamp range")

endmodule

>>> tb/tb_polar_to_cartesian_range_gate.sv
`timescale 1ns / 100ps

module tb_polar_to_cartesian_range_gate;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 3;
  localparam int STALL_LIMIT = 2000;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ARC_TURN [24] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  typedef struct {
    logic signed [p2c_pkg::OUT_W-1:0] x_mm;
    logic signed [p2c_pkg::OUT_W-1:0] y_mm;
    logic [p2c_pkg::INDEX_W-1:0]      index;
  } point_t;

  // register copy, cordic model and queue of expected points
  class point_tracker;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] range_floor;
    logic [15:0] range_ceiling;
    point_t      expected_points[$];
    int unsigned errors;

    function void load_defaults();
      start_angle   = '0;
      angle_step    = '0;
      range_floor   = '0;
      range_ceiling = 16'hFFFF;
    endfunction

    function void write_reg(p2c_pkg::reg_addr_t a, logic [15:0] v);
      case (a)
        p2c_pkg::REG_START_ANGLE:   start_angle = v;
        p2c_pkg::REG_ANGLE_STEP:    angle_step = v;
        p2c_pkg::REG_RANGE_FLOOR:   range_floor = v;
        p2c_pkg::REG_RANGE_CEILING: range_ceiling = v;
        default: ;
      endcase
    endfunction

    // q16 to millimeters, round half up, clamp
    function logic signed [p2c_pkg::OUT_W-1:0] q16_to_mm(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > 65535) begin
        r = 65535;
      end else if (r < -65535) begin
        r = -65535;
      end
      return r[p2c_pkg::OUT_W-1:0];
    endfunction

    function void note_sample(logic [p2c_pkg::RANGE_W-1:0] r,
                              logic [p2c_pkg::INDEX_W-1:0] idx);
      logic [15:0] ang;
      longint      s;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      bit          flip;
      point_t      p;
      // range gate, strict on both sides
      if (!(r > range_floor && r < range_ceiling)) return;
      // beam angle wraps modulo a full turn
      ang = start_angle + idx * angle_step;
      s = longint'($signed(ang));
      flip = 1'b0;
      if (s > 16384) begin
        s -= 32768;
        flip = 1'b1;
      end else if (s < -16384) begin
        s += 32768;
        flip = 1'b1;
      end
      // gain compensated start vector
      x = longint'((64'(r) * 64'(p2c_pkg::GAIN_Q32)) >> 16);
      if (flip) x = -x;
      y = 0;
      z = s * 65536;
      // rotation stages
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ARC_TURN[i];
        end else begin
          x += dx;
          y -= dy;
          z += ARC_TURN[i];
        end
      end
      p.x_mm = q16_to_mm(x);
      p.y_mm = q16_to_mm(y);
      p.index = idx;
      expected_points = {expected_points, p};
    endfunction

    function void check_point(logic signed [p2c_pkg::OUT_W-1:0] x,
                              logic signed [p2c_pkg::OUT_W-1:0] y,
                              logic [p2c_pkg::INDEX_W-1:0] idx);
      point_t p;
      if (expected_points.size() == 0) begin
        $display("%0t unexpected point x_mm %0d y_mm %0d point_index %0d", $time, x, y, idx);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x_mm) begin
        $display("%0t x_mm expected %0d actual %0d", $time, p.x_mm, x);
        errors++;
      end
      if (y !== p.y_mm) begin
        $display("%0t y_mm expected %0d actual %0d", $time, p.y_mm, y);
        errors++;
      end
      if (idx !== p.index) begin
        $display("%0t point_index expected %0d actual %0d", $time, p.index, idx);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [3:0]                          paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;
  logic                                in_valid;
  logic                                in_ready;
  logic [p2c_pkg::RANGE_W-1:0]         range_mm;
  logic [p2c_pkg::INDEX_W-1:0]         sample_index;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [p2c_pkg::OUT_W-1:0]    x_mm;
  logic signed [p2c_pkg::OUT_W-1:0]    y_mm;
  logic [p2c_pkg::INDEX_W-1:0]         point_index;

  point_tracker                        points;
  int unsigned                         quiet_cycles = 0;
  int unsigned                         gap_pct;
  int unsigned                         stall_pct;
  logic [15:0]                         cur_floor;
  logic [15:0]                         cur_ceiling;
  logic [p2c_pkg::INDEX_W-1:0]         next_index;

  polar_to_cartesian_range_gate #(
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .range_mm(range_mm),
    .sample_index(sample_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .x_mm(x_mm),
    .y_mm(y_mm),
    .point_index(point_index)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // random backpressure on the point side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) points.check_point(x_mm, y_mm, point_index);
      if (in_valid && in_ready) points.note_sample(range_mm, sample_index);
      if (psel && penable && pwrite && pready) begin
        points.write_reg(p2c_pkg::reg_addr_t'(paddr[3:2]), pwdata[15:0]);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one sample beat, then maybe a random gap
  task automatic send_sample(logic [p2c_pkg::RANGE_W-1:0] r,
                             logic [p2c_pkg::INDEX_W-1:0] idx);
    in_valid <= 1'b1;
    range_mm <= r;
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      range_mm <= p2c_pkg::RANGE_W'($urandom);
      sample_index <= p2c_pkg::INDEX_W'($urandom);
      do @(posedge clk); while ($urandom_range(3) == 0);
    end
  endtask

  // stop sending, wait for every expected point, then let rejected samples flush
  task automatic drain();
    in_valid <= 1'b0;
    while (points.expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic apb_write(p2c_pkg::reg_addr_t a, logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {a, 2'b00};
    pwdata <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_scan(logic [15:0] start, logic [15:0] step, logic [15:0] lo,
                          logic [15:0] hi);
    drain();
    apb_write(p2c_pkg::REG_START_ANGLE, start);
    apb_write(p2c_pkg::REG_ANGLE_STEP, step);
    apb_write(p2c_pkg::REG_RANGE_FLOOR, lo);
    apb_write(p2c_pkg::REG_RANGE_CEILING, hi);
    cur_floor = lo;
    cur_ceiling = hi;
  endtask

  // mostly in-window ranges, some on the window edges, some anywhere
  function automatic logic [p2c_pkg::RANGE_W-1:0] pick_range();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70 && int'(cur_floor) + 1 < int'(cur_ceiling)) begin
      return p2c_pkg::RANGE_W'($urandom_range(int'(cur_ceiling) - 1, int'(cur_floor) + 1));
    end else if (roll < 82) begin
      case ($urandom_range(3))
        0: return cur_floor;
        1: return cur_floor + 16'd1;
        2: return cur_ceiling - 16'd1;
        default: return cur_ceiling;
      endcase
    end
    return p2c_pkg::RANGE_W'($urandom);
  endfunction

  // scan-like index order with occasional jumps
  task automatic run_scan(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) next_index = p2c_pkg::INDEX_W'($urandom);
      send_sample(pick_range(), next_index);
      next_index++;
    end
  endtask

  initial begin
    logic [15:0] lo;
    points = new;
    points.load_defaults();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    range_mm = '0;
    sample_index = '0;
    gap_pct = 26;
    stall_pct = 26;
    next_index = '0;
    cur_floor = '0;
    cur_ceiling = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset window: range edges and index extremes
    send_sample(16'd0, 12'd0);
    send_sample(16'd1, 12'd0);
    send_sample(16'd65534, 12'd4095);
    send_sample(16'd65535, 12'd4095);
    send_sample(16'd40000, 12'd2048);

    // angles around the positive quarter turn
    set_scan(16'd16383, 16'd1, 16'd0, 16'hFFFF);
    send_sample(16'd65534, 12'd0);
    send_sample(16'd65534, 12'd1);
    send_sample(16'd65534, 12'd2);
    send_sample(16'd1, 12'd3);

    // negative quarter turn, narrow window
    set_scan(16'hBFFF, 16'd1, 16'd65533, 16'hFFFF);
    send_sample(16'd65534, 12'd0);
    send_sample(16'd65534, 12'd1);
    send_sample(16'd65534, 12'd2);
    send_sample(16'd65533, 12'd3);
    send_sample(16'd65535, 12'd4);

    // half turn and angle wrap with the most negative step
    set_scan(16'h8000, 16'h8000, 16'd65533, 16'hFFFF);
    send_sample(16'd65534, 12'd0);
    send_sample(16'd65534, 12'd1);
    send_sample(16'd65534, 12'd4095);

    // floor equal to ceiling keeps nothing
    set_scan(16'h7FFF, 16'h7FFF, 16'd500, 16'd500);
    send_sample(16'd499, 12'd0);
    send_sample(16'd500, 12'd1);
    send_sample(16'd501, 12'd2);

    // extreme register settings, full window
    set_scan(16'h7FFF, 16'h7FFF, 16'd0, 16'hFFFF);
    run_scan(250);
    set_scan(16'h8000, 16'h8000, 16'd0, 16'hFFFF);
    run_scan(250);

    // random settings, the first one with no idling on either side
    for (int p = 0; p < 4; p++) begin
      lo = 16'($urandom_range(40000));
      set_scan(16'($urandom), (p == 1) ? 16'($urandom_range(64, 1)) : 16'($urandom), lo,
               16'($urandom_range(65535, int'(lo) + 2)));
      if (p == 0) begin
        gap_pct = 0;
        stall_pct = 0;
        run_scan(300);
        gap_pct = 26;
        stall_pct = 26;
      end else begin
        run_scan(230);
      end
    end

    // floor above ceiling rejects every sample
    set_scan(16'($urandom), 16'($urandom), 16'hFFFF, 16'd0);
    run_scan(20);

    drain();
    if (points.errors == 0 && points.expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/p2c_pkg.sv
rtl/polar_to_cartesian_range_gate.sv
tb/tb_polar_to_cartesian_range_gate.sv
